>>> rtl/rectified_average_meter_macros.svh
// Assertion macros for the rectified average meter.
`ifndef RECTIFIED_AVERAGE_METER_MACROS_SVH
`define RECTIFIED_AVERAGE_METER_MACROS_SVH

`ifndef SYNTH
// ante holds at an edge -> cons holds at the same edge
`define RAVM_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ravm assertion failed");
// ante holds at an edge -> cons holds at the next edge
`define RAVM_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ravm assertion failed");
`else
`define RAVM_ASSERT_IMP(label, ck, rn, ante, cons)
`define RAVM_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

>>> rtl/ravm_pkg.sv
package ravm_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int VALUE_BITS     = 24;
    localparam int TICK_BITS      = 16;
    localparam int SUM_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [TICK_BITS-1:0] TICKS_RESET = 16'd201;

    localparam logic [2:0] MODE_SAMPLE   = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_TICK     = 3'd2;
    localparam logic [2:0] MODE_READ_AVG = 3'd3;
    localparam logic [2:0] MODE_READ_SUM = 3'd4;
    localparam logic [2:0] MODE_READ_CNT = 3'd5;

    typedef struct packed {
        logic [2:0]             mode;
        logic [SAMPLE_BITS-1:0] raw_sample;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic                  running;
    } rsp_t;

endpackage

>>> rtl/rectified_average_meter.sv
// Rectified average meter.
// Command channel (cmd_valid / cmd_stall / cmd): one beat per command: sample,
// start interval, tick, read average, read accumulator, read count.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per command,
// in order, carrying the reading (zero while the interval runs) and the
// running flag after the command.
// cfg_write / cfg_data load the interval length in ticks; write only while idle.
// Responses: a response is registered in the cycle after its command is taken,
// except a rounded-average read with a nonzero count, which runs a shift-subtract
// divider one quotient bit a cycle and then registers the quotient.
// Throughput: one command every cycle while responses drain; the divider holds
// cmd_stall high for the length of the division, and a response left waiting
// under rsp_stall holds off the next command.
// Reset clears the interval, sum and count, sets the interval length to 201
// and empties the response register. A stalled response holds its value.
`include "rectified_average_meter_macros.svh"

module rectified_average_meter #(
    parameter int SUM_BITS   = ravm_pkg::SUM_BITS_DEF,
    parameter int COUNT_BITS = ravm_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ravm_pkg::TICK_BITS-1:0]      cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  ravm_pkg::cmd_t                      cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ravm_pkg::rsp_t                      rsp
);
    import ravm_pkg::*;

    localparam int DVD_W  = SUM_BITS + 2;
    localparam int VSR_W  = COUNT_BITS + 1;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int SUM1_W = SUM_BITS + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                   state_reg, state_next;
    logic [TICK_BITS-1:0]   ticks_reg, ticks_next;
    logic                   active_reg, active_next;
    logic [TICK_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [DVD_W-1:0]       qr_reg, qr_next;
    logic [VSR_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic                   cmd_acc;
    logic                   rsp_free;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SUM1_W-1:0]      sum_add;
    logic [TICK_BITS-1:0]   tick_inc;
    logic [VSR_W-1:0]       divisor;
    logic [VSR_W:0]         shifted;
    logic [VSR_W:0]         diff;
    logic                   ge;
    logic [DVD_W-1:0]       qr_step;
    logic [VALUE_BITS-1:0]  value;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !rsp_free;
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // two's complement negate gives 2*h - raw for the negative half
    assign mag     = cmd.raw_sample[SAMPLE_BITS-1] ? (~cmd.raw_sample + 1'b1)
                                                   : cmd.raw_sample;
    assign sum_add = {1'b0, sum_reg} + SUM1_W'(mag);
    assign tick_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;

    // one restoring step of (2*sum + count) / (2*count)
    assign divisor = {count_reg, 1'b0};
    assign shifted = {rem_reg, qr_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign ge      = (shifted >= {1'b0, divisor});
    assign qr_step = {qr_reg[DVD_W-2:0], ge};

    always_comb
    begin
        state_next     = state_reg;
        ticks_next     = cfg_write ? cfg_data : ticks_reg;
        active_next    = active_reg;
        elapsed_next   = elapsed_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        qr_next        = qr_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        value          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    unique case (cmd.mode)
                        MODE_SAMPLE:
                        begin
                            if (active_reg)
                            begin
                                sum_next = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                                if (count_reg != '1)
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        MODE_START:
                        begin
                            if (!active_reg)
                            begin
                                active_next  = 1'b1;
                                elapsed_next = '0;
                                sum_next     = '0;
                                count_next   = '0;
                            end
                        end
                        MODE_TICK:
                        begin
                            if (active_reg)
                            begin
                                elapsed_next = tick_inc;
                                if (tick_inc >= ticks_reg)
                                begin
                                    active_next = 1'b0;
                                end
                            end
                        end
                        MODE_READ_SUM:
                        begin
                            if (!active_reg)
                            begin
                                value = VALUE_BITS'(sum_reg);
                            end
                        end
                        MODE_READ_CNT:
                        begin
                            if (!active_reg)
                            begin
                                value = VALUE_BITS'(count_reg);
                            end
                        end
                        default:
                        begin
                            value = '0;
                        end
                    endcase

                    if (cmd.mode == MODE_READ_AVG && !active_reg && count_reg != '0)
                    begin
                        state_next   = ST_DIV;
                        qr_next      = {1'b0, sum_reg, 1'b0} + DVD_W'(count_reg);
                        rem_next     = '0;
                        div_cnt_next = CNT_W'(DVD_W - 1);
                    end
                    else
                    begin
                        rsp_valid_next      = 1'b1;
                        rsp_next.read_value = value;
                        rsp_next.running    = active_next;
                    end
                end
            end
            ST_DIV:
            begin
                qr_next  = qr_step;
                rem_next = ge ? diff[VSR_W-1:0] : shifted[VSR_W-1:0];
                if (div_cnt_reg == '0)
                begin
                    state_next          = ST_IDLE;
                    rsp_valid_next      = 1'b1;
                    rsp_next.read_value = VALUE_BITS'(qr_step);
                    rsp_next.running    = active_reg;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ticks_reg     <= TICKS_RESET;
            active_reg    <= 1'b0;
            elapsed_reg   <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ticks_reg     <= ticks_next;
            active_reg    <= active_next;
            elapsed_reg   <= elapsed_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
        rsp_reg <= rsp_next;
    end

    `RAVM_ASSERT_IMP(a_div_blocks_cmd, clk, rst_n, state_reg == ST_DIV, cmd_stall)
    `RAVM_ASSERT_IMP(a_div_no_rsp, clk, rst_n, state_reg == ST_DIV, !rsp_valid_reg)
    `RAVM_ASSERT_NXT(a_div_done, clk, rst_n,
        state_reg == ST_DIV && div_cnt_reg == '0, state_reg == ST_IDLE && rsp_valid_reg)
    `RAVM_ASSERT_IMP(a_running_flag, clk, rst_n, rsp_valid_reg, rsp_reg.running == active_reg)
    `RAVM_ASSERT_NXT(a_start_clears, clk, rst_n,
        cmd_acc && cmd.mode == MODE_START && !active_reg,
        active_reg && sum_reg == '0 && count_reg == '0 && elapsed_reg == '0)

endmodule

>>> bench/tb_rectified_average_meter.sv
`timescale 1ns / 1ps

module tb_rectified_average_meter;

    import ravm_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 40;   // longest divide plus margin
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_SAMPLES = 240;
    localparam logic [15:0] LONG_TICKS = 16'd50;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [TICK_BITS-1:0] cfg_data = '0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    cmd_t                 cmd = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;

    // Predictor state
    logic                 meter_on;
    logic [15:0]          ticks_seen;
    logic [31:0]          mag_total;
    logic [15:0]          sample_total;
    logic [15:0]          interval_limit;

    rsp_t                 readings_due[$];
    int                   error_count = 0;
    int                   cycle_count = 0;
    int                   hold_request = 0;
    bit                   quiet = 1'b0;

    rectified_average_meter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_rectified_average_meter: errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("mismatch at cycle %0d: %s expected %0d got %0d",
                 cycle_count, what, want, got);
        error_count++;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 10'd511;
            2: return 10'd512;
            3: return 10'd1023;
            default: return SAMPLE_BITS'($urandom_range(0, 1023));
        endcase
    endfunction

    // Compute the response that one command beat produces, updating state.
    task automatic advance_meter(input cmd_t c);
        rsp_t        r;
        logic [10:0] mag;
        logic [32:0] wide;
        logic [33:0] num;
        logic [33:0] quo;
        logic [16:0] den;
        r = '0;
        case (c.mode)
            MODE_SAMPLE:
                if (meter_on)
                begin
                    mag = c.raw_sample[SAMPLE_BITS-1] ? 11'd1024 - {1'b0, c.raw_sample}
                                                      : {1'b0, c.raw_sample};
                    wide = {1'b0, mag_total} + 33'(mag);
                    mag_total = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
                    if (sample_total != 16'hFFFF)
                        sample_total++;
                end
            MODE_START:
                if (!meter_on)
                begin
                    meter_on = 1'b1;
                    ticks_seen = '0;
                    mag_total = '0;
                    sample_total = '0;
                end
            MODE_TICK:
                if (meter_on)
                begin
                    if (ticks_seen != 16'hFFFF)
                        ticks_seen++;
                    if (ticks_seen >= interval_limit)
                        meter_on = 1'b0;
                end
            MODE_READ_AVG:
                if (!meter_on && sample_total != 0)
                begin
                    // round half up: (2*sum + n) / (2*n)
                    num = {1'b0, mag_total, 1'b0} + 34'(sample_total);
                    den = {sample_total, 1'b0};
                    quo = num / {17'd0, den};
                    r.read_value = quo[VALUE_BITS-1:0];
                end
            MODE_READ_SUM:
                if (!meter_on)
                    r.read_value = mag_total[VALUE_BITS-1:0];
            MODE_READ_CNT:
                if (!meter_on)
                    r.read_value = {8'd0, sample_total};
            default: ;
        endcase
        r.running = meter_on;
        readings_due.push_back(r);
    endtask

    task automatic send_item(input logic [2:0] mode, input logic [SAMPLE_BITS-1:0] raw);
        int   gap;
        cmd_t c;
        gap = quiet ? 0 : idle_len();
        c.mode = mode;
        c.raw_sample = raw;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        advance_meter(c);
    endtask

    task automatic finish_beats();
        cmd_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_interval(input logic [15:0] ticks);
        finish_beats();
        cfg_write <= 1'b1;
        cfg_data <= ticks;
        @(posedge clk);
        cfg_write <= 1'b0;
        interval_limit = ticks;
    endtask

    // Response checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (readings_due.size() == 0)
            begin
                flag_mismatch("response beats pending", 0, 1);
            end
            else
            begin
                want = readings_due.pop_front();
                if (rsp.read_value !== want.read_value)
                    flag_mismatch("read_value", 32'(want.read_value), 32'(rsp.read_value));
                if (rsp.running !== want.running)
                    flag_mismatch("running", 32'(want.running), 32'(rsp.running));
            end
        end
    end

    // Response side: random stalls, plus long hold-offs on request
    initial
    begin
        int len;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                len = hold_request;
                hold_request = 0;
                rsp_stall <= 1'b1;
                repeat (len) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(15, 60);
                rsp_stall <= 1'b1;
                repeat (len) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic test_idle_commands();
        send_item(MODE_READ_AVG, 10'd0);
        send_item(MODE_READ_SUM, 10'd1023);
        send_item(MODE_READ_CNT, 10'd0);
        send_item(MODE_SAMPLE, 10'd512);   // ignored while idle
        send_item(MODE_TICK, 10'd0);       // ignored while idle
        send_item(MODE_SPARE_A, 10'd1023);
        send_item(MODE_SPARE_B, 10'd0);
    endtask

    task automatic test_short_interval();
        load_interval(16'd3);
        send_item(MODE_START, 10'd0);
        send_item(MODE_SAMPLE, 10'd0);
        send_item(MODE_SAMPLE, 10'd511);
        send_item(MODE_SAMPLE, 10'd512);
        send_item(MODE_SAMPLE, 10'd1023);
        send_item(MODE_START, 10'd0);      // no restart
        send_item(MODE_READ_AVG, 10'd0);   // zero while running
        send_item(MODE_READ_CNT, 10'd0);
        send_item(MODE_TICK, 10'd0);
        send_item(MODE_TICK, 10'd0);
        send_item(MODE_TICK, 10'd0);
        send_item(MODE_SAMPLE, 10'd100);   // after close, ignored
        send_item(MODE_READ_AVG, 10'd0);
        send_item(MODE_READ_SUM, 10'd0);
        send_item(MODE_READ_CNT, 10'd0);
    endtask

    // A zero length closes on the first tick; average of no samples reads zero.
    task automatic test_zero_interval();
        load_interval(16'd0);
        send_item(MODE_START, 10'd0);
        send_item(MODE_TICK, 10'd0);
        send_item(MODE_READ_AVG, 10'd0);
        send_item(MODE_READ_SUM, 10'd0);
    endtask

    task automatic test_stalled_readout();
        int i;
        load_interval(16'd4);
        quiet = 1'b1;
        hold_request = HOLD_CYCLES;
        send_item(MODE_START, 10'd0);
        for (i = 0; i < 8; i++)
            send_item(MODE_SAMPLE, pick_raw());
        for (i = 0; i < 4; i++)
            send_item(MODE_TICK, 10'd0);
        send_item(MODE_READ_AVG, 10'd0);
        send_item(MODE_READ_SUM, 10'd0);
        send_item(MODE_READ_CNT, 10'd0);
        finish_beats();
        quiet = 1'b0;
    endtask

    task automatic test_random_intervals();
        int          counted;
        int          pick;
        int          i;
        logic [15:0] ticks;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    ticks = 16'd1;
                else if (pick < 8)
                    ticks = 16'($urandom_range(2, 12));
                else
                    ticks = 16'($urandom_range(13, 64));
                load_interval(ticks);
            end
            // occasional noise while idle
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    send_item(MODE_SAMPLE, pick_raw());
                else if (pick == 1)
                    send_item(MODE_TICK, pick_raw());
                else if (pick == 2)
                    send_item($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B, pick_raw());
                else
                    send_item(3'($urandom_range(MODE_READ_AVG, MODE_READ_CNT)), pick_raw());
            end
            send_item(MODE_START, pick_raw());
            counted++;
            while (meter_on)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 58)
                    send_item(MODE_SAMPLE, pick_raw());
                else if (pick < 82)
                    send_item(MODE_TICK, pick_raw());
                else if (pick < 88)
                    send_item(3'($urandom_range(MODE_READ_AVG, MODE_READ_CNT)), pick_raw());
                else if (pick < 92)
                    send_item(MODE_START, pick_raw());
                else if (pick < 96)
                    send_item($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B, pick_raw());
                else
                    send_item(MODE_SAMPLE, pick_raw());
                if (pick < 88 || pick >= 96)
                    counted++;
            end
            for (i = 0; i < 3; i++)
            begin
                send_item(3'($urandom_range(MODE_READ_AVG, MODE_READ_CNT)), pick_raw());
                counted++;
            end
        end
        finish_beats();
        quiet = 1'b0;
    endtask

    // Long interval of mostly full-scale samples, fed back to back.
    task automatic test_long_interval();
        int i;
        load_interval(LONG_TICKS);
        quiet = 1'b1;
        send_item(MODE_START, 10'd0);
        for (i = 0; i < LONG_SAMPLES; i++)
            send_item(MODE_SAMPLE, ($urandom_range(0, 7) == 0) ? pick_raw()
                                                               : 10'd512);
        send_item(MODE_READ_CNT, 10'd0);
        for (i = 0; i < int'(LONG_TICKS); i++)
            send_item(MODE_TICK, 10'd0);
        send_item(MODE_SAMPLE, 10'd512);
        send_item(MODE_READ_AVG, 10'd0);
        send_item(MODE_READ_SUM, 10'd0);
        send_item(MODE_READ_CNT, 10'd0);
        finish_beats();
        quiet = 1'b0;
    endtask

    initial
    begin
        meter_on = 1'b0;
        ticks_seen = '0;
        mag_total = '0;
        sample_total = '0;
        interval_limit = TICKS_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_commands();
        test_short_interval();
        test_zero_interval();
        test_stalled_readout();
        test_random_intervals();
        test_long_interval();
        finish_beats();

        if (error_count == 0)
            $display("tb_rectified_average_meter: clean");
        else
            $display("tb_rectified_average_meter: errors");
        $finish;
    end

endmodule
